### hw/rtl/pgalloc_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Shared types, field widths, result codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgalloc_pkg;

    // Item field widths
    localparam int REQ_W  = 2;
    localparam int PROC_W = 8;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;

    // Process table and virtual page geometry
    localparam int PROC_TOTAL = 192;
    localparam int VPAGES     = 64;

    // Marker for a table or data page that could not be claimed
    localparam logic [VAL_W-1:0] FAIL_MARK = 8'hFF;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_TABLE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN  = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_NEW    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_LOOKUP,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_UNKNOWN,
        RES_NO_TABLE,
        RES_TABLE,
        RES_QUERY,
        RES_LOOKUP
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     claim_table;
        logic     fail_table;
        logic     data_step;
        logic     entry_read;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req;
        logic proc_ok;
        logic ptr_valid;
        logic page_free;
        logic cnt_zero;
        logic last_step;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/pgalloc_ctrl.sv
// ----------------------------------------------------------------------------
// Page allocator controller
// Sequences one item at a time: decode, data page loop or lookup, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_ctrl
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire pgalloc_pkg::sts_t   sts,
    output pgalloc_pkg::cmd_t        cmd
);

    pgalloc_pkg::state_t state_reg;
    pgalloc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pgalloc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pgalloc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pgalloc_pkg::S_DECODE;
                end
            end
            pgalloc_pkg::S_DECODE:
            begin
                state_next = pgalloc_pkg::S_FINISH;
                unique case (sts.req) inside
                    pgalloc_pkg::REQ_NEW:
                    begin
                        if (sts.proc_ok && sts.page_free && !sts.cnt_zero)
                        begin
                            state_next = pgalloc_pkg::S_ALLOC;
                        end
                    end
                    pgalloc_pkg::REQ_LOOKUP:
                    begin
                        if (sts.ptr_valid)
                        begin
                            state_next = pgalloc_pkg::S_LOOKUP;
                        end
                    end
                    pgalloc_pkg::REQ_QUERY,
                    pgalloc_pkg::REQ_NONE:
                    begin
                        state_next = pgalloc_pkg::S_FINISH;
                    end
                endcase
            end
            pgalloc_pkg::S_ALLOC:
            begin
                if (sts.last_step)
                begin
                    state_next = pgalloc_pkg::S_FINISH;
                end
            end
            pgalloc_pkg::S_LOOKUP:
            begin
                state_next = pgalloc_pkg::S_FINISH;
            end
            pgalloc_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = pgalloc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pgalloc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd         = '0;
        cmd.res_sel = pgalloc_pkg::RES_ZERO;
        in_ready    = 1'b0;
        unique case (state_reg)
            pgalloc_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            pgalloc_pkg::S_DECODE:
            begin
                cmd.res_load = 1'b1;
                unique case (sts.req)
                    pgalloc_pkg::REQ_NEW:
                    begin
                        if (!sts.proc_ok)
                        begin
                            cmd.res_sel = pgalloc_pkg::RES_UNKNOWN;
                        end
                        else if (!sts.page_free)
                        begin
                            cmd.fail_table = 1'b1;
                            cmd.res_sel    = pgalloc_pkg::RES_NO_TABLE;
                        end
                        else
                        begin
                            cmd.claim_table = 1'b1;
                            cmd.res_sel     = pgalloc_pkg::RES_TABLE;
                        end
                    end
                    pgalloc_pkg::REQ_LOOKUP:
                    begin
                        if (sts.ptr_valid)
                        begin
                            cmd.res_load   = 1'b0;
                            cmd.entry_read = 1'b1;
                        end
                        else
                        begin
                            cmd.res_sel = pgalloc_pkg::RES_UNKNOWN;
                        end
                    end
                    pgalloc_pkg::REQ_QUERY:
                    begin
                        cmd.res_sel = pgalloc_pkg::RES_QUERY;
                    end
                    pgalloc_pkg::REQ_NONE:
                    begin
                        cmd.res_sel = pgalloc_pkg::RES_ZERO;
                    end
                endcase
            end
            pgalloc_pkg::S_ALLOC:
            begin
                cmd.data_step = 1'b1;
            end
            pgalloc_pkg::S_LOOKUP:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = pgalloc_pkg::RES_LOOKUP;
            end
            pgalloc_pkg::S_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/pgalloc_dp.sv
// ----------------------------------------------------------------------------
// Page allocator datapath
// Free page counter, process pointer store, page table store, result
// and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_dp
#(
    parameter int PAGE_TOTAL = 64
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire pgalloc_pkg::cmd_t             cmd,
    output pgalloc_pkg::sts_t                  sts,
    input  wire  [pgalloc_pkg::REQ_W-1:0]      req_type,
    input  wire  [pgalloc_pkg::PROC_W-1:0]     proc_id,
    input  wire  [pgalloc_pkg::CNT_W-1:0]      page_request_count,
    input  wire  [pgalloc_pkg::IDX_W-1:0]      page_index,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [pgalloc_pkg::STAT_W-1:0]     status,
    output logic [pgalloc_pkg::VAL_W-1:0]      page_value,
    output logic [pgalloc_pkg::CNT_W-1:0]      pages_failed
);

    localparam int PW  = $clog2(PAGE_TOTAL);
    localparam int NFW = $clog2(PAGE_TOTAL + 1);
    localparam int QW  = (NFW > pgalloc_pkg::IDX_W) ? NFW : pgalloc_pkg::IDX_W;
    localparam int CW  = pgalloc_pkg::CNT_W;
    localparam int EW  = PW + pgalloc_pkg::IDX_W;
    localparam int VW  = pgalloc_pkg::VAL_W;

    // Latched item
    pgalloc_pkg::req_t             req_reg;
    logic [pgalloc_pkg::PROC_W-1:0] proc_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [pgalloc_pkg::IDX_W-1:0] idx_reg;

    // Pages are never released and always taken lowest first, so the used
    // map is the range below next_free_reg.
    logic [NFW-1:0]                next_free_reg;
    logic [pgalloc_pkg::PROC_TOTAL-1:0] valid_reg;

    // Pointer store: table page and clamped page count per process
    logic [PW+CW-1:0] ptr_mem [pgalloc_pkg::PROC_TOTAL];
    logic [PW+CW-1:0] ptr_rd_reg;
    logic [PW-1:0]    ptr_page;
    logic [CW-1:0]    ptr_cnt;

    // Page table store
    logic [VW-1:0]    ent_mem [PAGE_TOTAL * pgalloc_pkg::VPAGES];
    logic [VW-1:0]    ent_rd_reg;

    logic [PW-1:0]                 table_reg;
    logic [pgalloc_pkg::IDX_W-1:0] step_reg;

    logic [pgalloc_pkg::STAT_W-1:0] res_status_reg;
    logic [VW-1:0]                  res_value_reg;
    logic [CW-1:0]                  res_failed_reg;

    logic [pgalloc_pkg::STAT_W-1:0] status_reg;
    logic [VW-1:0]                  value_reg;
    logic [CW-1:0]                  failed_reg;
    logic                           out_valid_reg;

    logic          page_free;
    logic          hit;
    logic          query_used;
    logic [CW-1:0] cnt_clamped;

    assign ptr_page     = ptr_rd_reg[PW+CW-1:CW];
    assign ptr_cnt      = ptr_rd_reg[CW-1:0];
    assign page_free    = (next_free_reg < NFW'(PAGE_TOTAL));
    assign hit          = ({1'b0, idx_reg} < ptr_cnt);
    assign query_used   = (QW'(idx_reg) < QW'(next_free_reg));
    assign cnt_clamped  = (page_request_count > CW'(pgalloc_pkg::VPAGES))
                          ? CW'(pgalloc_pkg::VPAGES) : page_request_count;

    always_comb
    begin
        sts.req       = req_reg;
        sts.proc_ok   = (proc_reg < pgalloc_pkg::PROC_W'(pgalloc_pkg::PROC_TOTAL));
        sts.ptr_valid = sts.proc_ok && valid_reg[proc_reg];
        sts.page_free = page_free;
        sts.cnt_zero  = (cnt_reg == '0);
        sts.last_step = ((CW'(step_reg) + CW'(1)) == cnt_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= NFW'(1);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.claim_table || (cmd.data_step && page_free))
            begin
                next_free_reg <= next_free_reg + NFW'(1);
            end
            if (cmd.claim_table)
            begin
                valid_reg[proc_reg] <= 1'b1;
            end
            else if (cmd.fail_table)
            begin
                valid_reg[proc_reg] <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item latch, loop registers, result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= pgalloc_pkg::req_t'(req_type);
            proc_reg <= proc_id;
            cnt_reg  <= cnt_clamped;
            idx_reg  <= page_index;
        end
        if (cmd.claim_table)
        begin
            table_reg <= next_free_reg[PW-1:0];
            step_reg  <= '0;
        end
        else if (cmd.data_step)
        begin
            step_reg <= step_reg + pgalloc_pkg::IDX_W'(1);
        end
        if (cmd.res_load)
        begin
            res_failed_reg <= '0;
            unique case (cmd.res_sel)
                pgalloc_pkg::RES_ZERO:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_OK;
                    res_value_reg  <= '0;
                end
                pgalloc_pkg::RES_UNKNOWN:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_UNKNOWN;
                    res_value_reg  <= '0;
                end
                pgalloc_pkg::RES_NO_TABLE:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_NO_TABLE;
                    res_value_reg  <= pgalloc_pkg::FAIL_MARK;
                end
                pgalloc_pkg::RES_TABLE:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_OK;
                    res_value_reg  <= VW'(next_free_reg);
                end
                pgalloc_pkg::RES_QUERY:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_OK;
                    res_value_reg  <= VW'(query_used);
                end
                pgalloc_pkg::RES_LOOKUP:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_OK;
                    res_value_reg  <= hit ? ent_rd_reg : '0;
                end
                default:
                begin
                    res_status_reg <= pgalloc_pkg::STAT_OK;
                    res_value_reg  <= '0;
                end
            endcase
        end
        else if (cmd.data_step && !page_free)
        begin
            res_failed_reg <= res_failed_reg + CW'(1);
        end
        if (cmd.out_load)
        begin
            status_reg <= res_status_reg;
            value_reg  <= res_value_reg;
            failed_reg <= res_failed_reg;
        end
    end

    // Pointer store: read at item accept, write when a table is claimed
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (proc_id < pgalloc_pkg::PROC_W'(pgalloc_pkg::PROC_TOTAL)))
        begin
            ptr_rd_reg <= ptr_mem[proc_id];
        end
        if (cmd.claim_table)
        begin
            ptr_mem[proc_reg] <= {next_free_reg[PW-1:0], cnt_reg};
        end
    end

    // Page table store: read for a lookup, one entry written per loop step
    always_ff @(posedge clk)
    begin
        if (cmd.entry_read)
        begin
            ent_rd_reg <= ent_mem[{ptr_page, idx_reg}];
        end
        if (cmd.data_step)
        begin
            ent_mem[EW'({table_reg, step_reg})] <= page_free ? VW'(next_free_reg)
                                                             : pgalloc_pkg::FAIL_MARK;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign page_value   = value_reg;
    assign pages_failed = failed_reg;

endmodule

`default_nettype wire

### hw/rtl/page_allocator_with_page_tables.sv
// Steps from accept to out_valid: decode; then one data page step per requested page, clamped
// to 64, for a new process that claims a table, or a page table store read for a lookup of a
// known process; then the result stage. Only one item is in flight: the next item is taken in
// the idle state, entered once the result is loaded into the output register. A result still
// waiting in the output register holds the controller until it is taken.
// Reset (rst_n low, asynchronous): page zero used, all others free, no tables, output empty.
// ----------------------------------------------------------------------------
// First-fit physical page allocator with per-process page tables
// Top level: joins the sequencing controller and the allocator datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module page_allocator_with_page_tables
#(
    parameter int PAGE_TOTAL = 64
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [pgalloc_pkg::REQ_W-1:0]      req_type,
    input  wire  [pgalloc_pkg::PROC_W-1:0]     proc_id,
    input  wire  [pgalloc_pkg::CNT_W-1:0]      page_request_count,
    input  wire  [pgalloc_pkg::IDX_W-1:0]      page_index,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [pgalloc_pkg::STAT_W-1:0]     status,
    output logic [pgalloc_pkg::VAL_W-1:0]      page_value,
    output logic [pgalloc_pkg::CNT_W-1:0]      pages_failed
);

    // Command and status between controller and datapath
    pgalloc_pkg::cmd_t cmd;
    pgalloc_pkg::sts_t sts;

    // Controller: accepts an item only in its idle state, then walks the
    // decode, data page loop or lookup, and hands the result to the output
    // register once that register is free.
    pgalloc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: holds the free page counter, the process pointer store with
    // its valid bits, the page table store and the output register, which
    // parts the input side from a stalled consumer.
    pgalloc_dp
    #(
        .PAGE_TOTAL (PAGE_TOTAL)
    )
    u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .req_type           (req_type),
        .proc_id            (proc_id),
        .page_request_count (page_request_count),
        .page_index         (page_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .page_value         (page_value),
        .pages_failed       (pages_failed)
    );

endmodule

`default_nettype wire

### hw/rtl/pgalloc_chk.sv
// ----------------------------------------------------------------------------
// Page allocator port checker
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_chk
(
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_valid,
    input wire                                in_ready,
    input wire [pgalloc_pkg::REQ_W-1:0]       req_type,
    input wire [pgalloc_pkg::PROC_W-1:0]      proc_id,
    input wire [pgalloc_pkg::CNT_W-1:0]       page_request_count,
    input wire [pgalloc_pkg::IDX_W-1:0]       page_index,
    input wire                                out_valid,
    input wire                                out_ready,
    input wire [pgalloc_pkg::STAT_W-1:0]      status,
    input wire [pgalloc_pkg::VAL_W-1:0]       page_value,
    input wire [pgalloc_pkg::CNT_W-1:0]       pages_failed
);

    // One item at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // Offered item holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=>
        (in_valid && $stable(req_type) && $stable(proc_id) &&
         $stable(page_request_count) && $stable(page_index)))
        else $error("offered item changed before accept");

    // Failed table claim reports the marker and no failed data pages
    a_no_table_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == pgalloc_pkg::STAT_NO_TABLE) |->
        (page_value == pgalloc_pkg::FAIL_MARK && pages_failed == '0))
        else $error("bad result for failed table claim");

    // Unknown process reports zero value and zero failures
    a_unknown_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == pgalloc_pkg::STAT_UNKNOWN) |->
        (page_value == '0 && pages_failed == '0))
        else $error("bad result for unknown process");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(status) && $stable(page_value) && $stable(pages_failed)))
        else $error("stalled result changed");

endmodule

bind page_allocator_with_page_tables pgalloc_chk u_chk
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .req_type           (req_type),
    .proc_id            (proc_id),
    .page_request_count (page_request_count),
    .page_index         (page_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .page_value         (page_value),
    .pages_failed       (pages_failed)
);

`default_nettype wire
